// File: hdl/tcrt_pkg.sv
// ----------------------------------------------------------------------------
// tcrt_pkg: shared definitions for the three-channel reload timer unit
// Widths, opcodes, register map and the channel command/status records.
// ----------------------------------------------------------------------------
package tcrt_pkg;

	// Number of timer channels (the 4-bit register index fits 1 to 5)
	localparam int CHANNELS = 3;

	// Register and field widths
	localparam int CNT_W     = 32;
	localparam int CTRL_W    = 16;
	localparam int OPCODE_W  = 2;
	localparam int IDX_W     = 4;
	localparam int DATA_W    = 32;
	localparam int IRQ_W     = 3;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Register index wide enough to compare against the whole map
	localparam int IDX_EXT_W = 5;

	// Control word bits
	localparam int UNDERFLOW_BIT = 8;
	localparam int ENABLE_BIT    = 5;

	// Register map
	localparam logic [IDX_W-1:0] REG_START = 4'd0;
	localparam int CTRL_BASE = 1;
	localparam int CNT_BASE  = 1 + CHANNELS;
	localparam int RLD_BASE  = 1 + 2 * CHANNELS;

	// Reset value of counters and reload constants
	localparam logic [CNT_W-1:0] COUNTER_RESET = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// Per-channel command for one transaction
	typedef struct packed {
		logic              tick;
		logic              run;
		logic              wr_ctrl;
		logic              wr_cnt;
		logic              wr_rld;
		logic [DATA_W-1:0] wdata;
	} chan_cmd_t;

	// Per-channel register contents and next interrupt line
	typedef struct packed {
		logic [CTRL_W-1:0] ctrl;
		logic [CNT_W-1:0]  cnt;
		logic [CNT_W-1:0]  rld;
		logic              irq_next;
	} chan_stat_t;

endpackage

// File: hdl/tcrt_chan.sv
// ----------------------------------------------------------------------------
// tcrt_chan: one timer channel
// Down counter, reload constant and control word, updated by tick or write.
// ----------------------------------------------------------------------------
module tcrt_chan (
	input  logic               clk,
	input  logic               arst_n,
	input  tcrt_pkg::chan_cmd_t cmd,
	output tcrt_pkg::chan_stat_t stat
);
	import tcrt_pkg::*;

	logic [CTRL_W-1:0] ctrl_q, ctrl_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  rld_q, rld_d;

	// Next-state logic for tick and register writes
	always_comb begin
		ctrl_d = ctrl_q;
		cnt_d  = cnt_q;
		rld_d  = rld_q;
		if (cmd.tick && cmd.run) begin
			if (cnt_q == '0) begin
				cnt_d = rld_q;
				ctrl_d[UNDERFLOW_BIT] = 1'b1;
			end else begin
				cnt_d = cnt_q - CNT_W'(1);
			end
		end
		// Writing 0 to the underflow bit clears it, 1 leaves it
		if (cmd.wr_ctrl) begin
			ctrl_d = cmd.wdata[CTRL_W-1:0];
			ctrl_d[UNDERFLOW_BIT] = cmd.wdata[UNDERFLOW_BIT] & ctrl_q[UNDERFLOW_BIT];
		end
		if (cmd.wr_cnt) begin
			cnt_d = cmd.wdata[CNT_W-1:0];
		end
		if (cmd.wr_rld) begin
			rld_d = cmd.wdata[CNT_W-1:0];
		end
	end

	// Channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			cnt_q  <= COUNTER_RESET;
			rld_q  <= COUNTER_RESET;
		end else begin
			ctrl_q <= ctrl_d;
			cnt_q  <= cnt_d;
			rld_q  <= rld_d;
		end
	end

	assign stat.ctrl     = ctrl_q;
	assign stat.cnt      = cnt_q;
	assign stat.rld      = rld_q;
	assign stat.irq_next = ctrl_d[UNDERFLOW_BIT] & ctrl_d[ENABLE_BIT];

endmodule

// File: hdl/three_channel_reload_timer_unit.sv
// Pipeline: an accepted transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle; the input register and the result
// register stall only when the result side is not taking results.
// Reset: arst_n clears run bits and control words and sets counters and
// reload constants to all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
// three_channel_reload_timer_unit: programmable reload down-counter timers
// Ticks, register reads and writes arrive as stream transactions; each one
// returns read data and the interrupt lines after its update.
// ----------------------------------------------------------------------------
module three_channel_reload_timer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] opcode, [5:2] reg_index, [37:6] write_data, [39:38] zero
	input  logic [tcrt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] read_data, [34:32] irq_lines, [39:35] zero
	output logic [tcrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import tcrt_pkg::*;

	// Input register stage
	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [DATA_W-1:0]   wdata_s1;

	// Result register
	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic [IRQ_W-1:0]  irq_q;

	logic [CHANNELS-1:0] run_q;

	logic                advance;
	opcode_t             op;
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                is_tick, is_read, is_write;
	logic [DATA_W-1:0]   read_data_d;
	logic [CHANNELS-1:0] irq_all;

	chan_cmd_t  chan_cmd [CHANNELS];
	chan_stat_t chan_st  [CHANNELS];

	// Handshake: stage 1 moves into the result register when it is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tdata[1:0];
			idx_s1    <= s_axis_tdata[5:2];
			wdata_s1  <= s_axis_tdata[37:6];
		end
	end

	// Decode the transaction in stage 1
	assign op       = opcode_t'(opcode_s1);
	assign idx_ext  = IDX_EXT_W'(idx_s1);
	assign is_tick  = advance && (op == OP_TICK);
	assign is_read  = (op == OP_READ);
	assign is_write = advance && (op == OP_WRITE);

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			chan_cmd[c].tick    = is_tick;
			chan_cmd[c].run     = run_q[c];
			chan_cmd[c].wr_ctrl = is_write && (idx_ext == IDX_EXT_W'(CTRL_BASE + c));
			chan_cmd[c].wr_cnt  = is_write && (idx_ext == IDX_EXT_W'(CNT_BASE + c));
			chan_cmd[c].wr_rld  = is_write && (idx_ext == IDX_EXT_W'(RLD_BASE + c));
			chan_cmd[c].wdata   = wdata_s1;
		end
	end

	// Start register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (is_write && (idx_s1 == REG_START)) begin
			run_q <= wdata_s1[CHANNELS-1:0];
		end
	end

	// Channels
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		tcrt_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (chan_cmd[g]),
			.stat   (chan_st[g])
		);
	end

	// Read mux; unmapped indices and non-read opcodes give zero
	always_comb begin
		read_data_d = '0;
		irq_all     = '0;
		if (is_read && (idx_s1 == REG_START)) begin
			read_data_d = DATA_W'(run_q);
		end
		for (int c = 0; c < CHANNELS; c++) begin
			irq_all[c] = chan_st[c].irq_next;
			if (is_read) begin
				if (idx_ext == IDX_EXT_W'(CTRL_BASE + c)) begin
					read_data_d = DATA_W'(chan_st[c].ctrl);
				end
				if (idx_ext == IDX_EXT_W'(CNT_BASE + c)) begin
					read_data_d = chan_st[c].cnt;
				end
				if (idx_ext == IDX_EXT_W'(RLD_BASE + c)) begin
					read_data_d = chan_st[c].rld;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= read_data_d;
			irq_q       <= IRQ_W'(irq_all);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - IRQ_W){1'b0}}, irq_q, read_data_q};

	// Checks
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && !run_q[0] && !chan_cmd[0].wr_cnt) |=> $stable(chan_st[0].cnt))
		else $error("stopped channel counted");

	a_tick_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && run_q[0] && (chan_st[0].cnt != '0))
		|=> (chan_st[0].cnt == $past(chan_st[0].cnt) - CNT_W'(1)))
		else $error("running channel did not decrement");

	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_cmd[0].wr_ctrl && !wdata_s1[UNDERFLOW_BIT])
		|=> !chan_st[0].ctrl[UNDERFLOW_BIT])
		else $error("underflow flag not cleared by write");

endmodule

// File: bench/tb_three_channel_reload_timer_unit.sv
// ----------------------------------------------------------------------------
// tb_three_channel_reload_timer_unit: self-checking bench for the timer unit
// Drives ticks, register reads and writes into the slave stream and keeps a
// cycle-free model of the three channels. Every result transaction is
// checked field by field against the oldest prediction, under random source
// gaps, random sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_three_channel_reload_timer_unit;

	import tcrt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [IDX_W-1:0] IDX_TOP = '1;

	// Expected contents of one result transaction
	typedef struct {
		logic [DATA_W-1:0] read_data;
		logic [IRQ_W-1:0]  irq_lines;
	} timer_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Timer state as the bench predicts it
	logic [CHANNELS-1:0] run_bits;
	logic [CTRL_W-1:0]   ctrl_words [CHANNELS];
	logic [CNT_W-1:0]    down_counts [CHANNELS];
	logic [CNT_W-1:0]    reload_consts [CHANNELS];

	timer_result_t pending_results [$];

	// Traffic shaping shared with the sink process
	bit src_gaps = 1'b0;
	bit sink_gaps = 1'b0;
	int hold_cycles = 0;

	int error_count = 0;
	int checked_count = 0;
	int tick_count = 0;
	int read_count = 0;
	int write_count = 0;
	int nop_count = 0;
	int underflow_count = 0;
	int stall_cycles = 0;

	three_channel_reload_timer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Apply one transaction to the predicted timer state
	function automatic timer_result_t timer_step(opcode_t op, logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] data);
		timer_result_t res;
		logic [CTRL_W-1:0] new_ctrl;
		res.read_data = '0;
		res.irq_lines = '0;
		case (op)
			OP_TICK: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (run_bits[c]) begin
						if (down_counts[c] == '0) begin
							down_counts[c] = reload_consts[c];
							ctrl_words[c][UNDERFLOW_BIT] = 1'b1;
							underflow_count++;
						end else begin
							down_counts[c] = down_counts[c] - 1;
						end
					end
				end
			end
			OP_READ: begin
				if (idx == REG_START)
					res.read_data[CHANNELS-1:0] = run_bits;
				else if (idx < CNT_BASE)
					res.read_data[CTRL_W-1:0] = ctrl_words[idx - CTRL_BASE];
				else if (idx < RLD_BASE)
					res.read_data = down_counts[idx - CNT_BASE];
				else if (idx < RLD_BASE + CHANNELS)
					res.read_data = reload_consts[idx - RLD_BASE];
			end
			OP_WRITE: begin
				if (idx == REG_START) begin
					run_bits = data[CHANNELS-1:0];
				end else if (idx < CNT_BASE) begin
					// a written 1 in the underflow bit keeps the flag, a 0 clears it
					new_ctrl = data[CTRL_W-1:0];
					new_ctrl[UNDERFLOW_BIT] = new_ctrl[UNDERFLOW_BIT] &
						ctrl_words[idx - CTRL_BASE][UNDERFLOW_BIT];
					ctrl_words[idx - CTRL_BASE] = new_ctrl;
				end else if (idx < RLD_BASE) begin
					down_counts[idx - CNT_BASE] = data;
				end else if (idx < RLD_BASE + CHANNELS) begin
					reload_consts[idx - RLD_BASE] = data;
				end
			end
			default: ;
		endcase
		for (int c = 0; c < CHANNELS && c < IRQ_W; c++)
			res.irq_lines[c] = ctrl_words[c][UNDERFLOW_BIT] & ctrl_words[c][ENABLE_BIT];
		return res;
	endfunction

	// Offer one transaction; entered and left just after a falling edge
	task automatic send_item(opcode_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		while (src_gaps && $urandom_range(0, 99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, data, idx, op};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(timer_step(op, idx, data));
		case (op)
			OP_TICK:  tick_count++;
			OP_READ:  read_count++;
			OP_WRITE: write_count++;
			default:  nop_count++;
		endcase
		@(negedge clk);
	endtask

	// Reset contents, unused indices and the unused opcode
	task automatic test_reset_state();
		send_item(OP_READ, REG_START, '0);
		send_item(OP_READ, IDX_W'(CTRL_BASE), '0);
		send_item(OP_READ, IDX_W'(CNT_BASE), '0);
		send_item(OP_READ, IDX_W'(RLD_BASE), '0);
		send_item(OP_READ, IDX_W'(RLD_BASE + CHANNELS), '0);
		send_item(OP_READ, IDX_TOP, '1);
		send_item(OP_NOP, IDX_TOP, '1);
	endtask

	// Start bits, zero counter reload and ignored writes
	task automatic test_underflow_reload();
		send_item(OP_WRITE, REG_START, '1);
		send_item(OP_READ, REG_START, '0);
		send_item(OP_WRITE, IDX_W'(CTRL_BASE), 32'h0000_0020);
		send_item(OP_WRITE, IDX_W'(CNT_BASE), '0);
		send_item(OP_WRITE, IDX_W'(RLD_BASE), '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, IDX_TOP, '1);
		send_item(OP_WRITE, IDX_TOP, '1);
		send_item(OP_READ, IDX_W'(CNT_BASE + 1), '0);
	endtask

	// Underflow flag under control writes, stopped channels
	task automatic test_flag_writes();
		send_item(OP_WRITE, IDX_W'(CTRL_BASE), '1);
		send_item(OP_READ, IDX_W'(CTRL_BASE), '0);
		send_item(OP_WRITE, IDX_W'(CTRL_BASE), 32'h0000_0020);
		send_item(OP_WRITE, IDX_W'(CTRL_BASE + 2), '1);
		send_item(OP_READ, IDX_W'(CTRL_BASE + 2), '0);
		send_item(OP_WRITE, IDX_W'(CNT_BASE + 2), '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_WRITE, REG_START, '0);
		send_item(OP_TICK, '0, '0);
	endtask

	// Mostly ticks with small counts so channels wrap often
	task automatic test_random_traffic(int count);
		opcode_t op;
		logic [IDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				op = OP_TICK;
			else if (pick < 70)
				op = OP_READ;
			else if (pick < 96)
				op = OP_WRITE;
			else
				op = OP_NOP;
			idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 15)) :
				IDX_W'($urandom_range(0, RLD_BASE + CHANNELS - 1));
			data = $urandom();
			if (op == OP_WRITE && idx >= CNT_BASE && $urandom_range(0, 3) != 0)
				data = $urandom_range(0, 6);
			if (op == OP_WRITE && idx == REG_START && $urandom_range(0, 1) == 1)
				data[CHANNELS-1:0] = '1;
			send_item(op, idx, data);
		end
	endtask

	// Sink holds off while the source keeps offering, so the input stalls
	task automatic test_result_backpressure();
		// the last transaction is already taken; stop offering it
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		hold_cycles = HOLD_CYCLES;
		@(negedge clk);
		repeat (24)
			send_item(opcode_t'($urandom_range(0, 1)),
				IDX_W'($urandom_range(0, 15)), $urandom());
	endtask

	// Sink ready: long hold-off, random stalls or always ready
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else if (sink_gaps) begin
				m_axis_tready <= ($urandom_range(0, 99) >= 29);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			checked_count++;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, actual tdata %h", $time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[DATA_W-1:0] !== want.read_data) begin
					error_count++;
					$display("%0t: read_data expected %h actual %h", $time,
						want.read_data, m_axis_tdata[DATA_W-1:0]);
				end
				if (m_axis_tdata[DATA_W +: IRQ_W] !== want.irq_lines) begin
					error_count++;
					$display("%0t: irq_lines expected %b actual %b", $time,
						want.irq_lines, m_axis_tdata[DATA_W +: IRQ_W]);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("three_channel_reload_timer_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		run_bits = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			ctrl_words[c] = '0;
			down_counts[c] = COUNTER_RESET;
			reload_consts[c] = COUNTER_RESET;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		test_underflow_reload();
		test_flag_writes();

		// back-to-back stretch without any idling
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random_traffic(RANDOM_ITEMS / 4);

		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		test_result_backpressure();
		test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 4);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d transactions: %0d ticks, %0d reads, %0d writes, %0d no-ops",
			tick_count + read_count + write_count + nop_count, tick_count, read_count,
			write_count, nop_count);
		$display("%0d results checked, %0d channel underflows, one long sink hold-off",
			checked_count, underflow_count);
		if (error_count == 0)
			$display("three_channel_reload_timer_unit: match");
		else
			$display("three_channel_reload_timer_unit: mismatch");
		$finish;
	end

endmodule
